// File: rtl/core/rv32x_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rv32x_pkg
// Shared constants, opcode codes and stage types for the RV32I execute block.
// ============================================================================
package rv32x_pkg;

    localparam int unsigned XLEN           = 32;
    localparam int unsigned REG_COUNT      = 32;
    localparam int unsigned DATA_MEM_BYTES = 65536;           // power of two, 16 .. 1M
    localparam int unsigned DMEM_AW        = $clog2(DATA_MEM_BYTES);
    localparam int unsigned DMEM_ROW_W     = DMEM_AW - 2;     // four byte lanes
    localparam int unsigned DMEM_ROWS      = DATA_MEM_BYTES / 4;

    typedef logic [XLEN-1:0]       t_word;
    typedef logic [4:0]            t_reg_idx;
    typedef logic [DMEM_AW-1:0]    t_dmem_addr;
    typedef logic [DMEM_ROW_W-1:0] t_dmem_row;

    // major opcodes
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam t_word ECALL_WORD = 32'h0000_0073;

    // ALU funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // load / store funct3
    localparam logic [2:0] F3_LB  = 3'd0;
    localparam logic [2:0] F3_LH  = 3'd1;
    localparam logic [2:0] F3_LW  = 3'd2;
    localparam logic [2:0] F3_LBU = 3'd4;
    localparam logic [2:0] F3_LHU = 3'd5;
    localparam logic [2:0] F3_SB  = 3'd0;
    localparam logic [2:0] F3_SH  = 3'd1;
    localparam logic [2:0] F3_SW  = 3'd2;

    // branch funct3
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    localparam t_reg_idx REG_ZERO = 5'd0;
    localparam t_reg_idx REG_A0   = 5'd10;
    localparam t_reg_idx REG_A7   = 5'd17;

    // execute stage result, carried into the memory stage
    typedef struct packed {
        t_word      next_pc;
        logic       wr;          // nonzero rd written
        t_reg_idx   rd;
        t_word      val;         // ALU / LUI / JAL value, zero for loads
        logic       is_load;
        logic [2:0] ld_f3;
        t_dmem_addr mem_addr;
        logic       is_store;
        logic [2:0] st_f3;
        t_word      st_data;
        logic       illegal;
        logic       ecall;
        t_word      ecall_num;
        t_word      ecall_arg;
    } t_exec_res;

    // register file write port
    typedef struct packed {
        logic     en;
        t_reg_idx addr;
        t_word    data;
    } t_rf_wr;

endpackage

// File: rtl/core/rv32x_if.sv
`timescale 1ns / 1ps
// ============================================================================
// rv32x_if
// Valid/ready channels for instruction words in and execution results out.
// ============================================================================
interface rv32x_ins_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction;

    modport source (output valid, output instruction, input ready);
    modport sink   (input valid, input instruction, output ready);
endinterface

interface rv32x_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  dest_reg;
    logic [31:0] dest_value;
    logic        mem_written;
    logic        illegal;
    logic        ecall_seen;
    logic [31:0] ecall_number;
    logic [31:0] ecall_argument;

    modport source (output valid, output next_pc, output reg_written, output dest_reg,
                    output dest_value, output mem_written, output illegal,
                    output ecall_seen, output ecall_number, output ecall_argument,
                    input ready);
    modport sink   (input valid, input next_pc, input reg_written, input dest_reg,
                    input dest_value, input mem_written, input illegal,
                    input ecall_seen, input ecall_number, input ecall_argument,
                    output ready);
endinterface

// File: rtl/core/rv32x_regfile.sv
`timescale 1ns / 1ps
// ============================================================================
// rv32x_regfile
// 32 x 32 register file: two registered read ports, one write port, valid
// bits for reset-to-zero, and live copies of a0 and a7.
// ============================================================================
module rv32x_regfile (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rv32x_pkg::t_reg_idx i_rd_addr1,
    input  rv32x_pkg::t_reg_idx i_rd_addr2,
    output rv32x_pkg::t_word    o_rd_data1,
    output rv32x_pkg::t_word    o_rd_data2,
    input  rv32x_pkg::t_rf_wr   i_wr,
    output rv32x_pkg::t_word    o_a0,
    output rv32x_pkg::t_word    o_a7
);

    rv32x_pkg::t_word                    rf_mem [rv32x_pkg::REG_COUNT];
    logic [rv32x_pkg::REG_COUNT-1:0]     r_valid;
    rv32x_pkg::t_word                    r_q1, r_q2;
    logic                                r_v1, r_v2;
    rv32x_pkg::t_word                    r_a0, r_a7;

    // storage and registered reads (read-before-write on a shared edge)
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            rf_mem[i_wr.addr] <= i_wr.data;
        end
        r_q1 <= rf_mem[i_rd_addr1];
        r_q2 <= rf_mem[i_rd_addr2];
        r_v1 <= r_valid[i_rd_addr1];
        r_v2 <= r_valid[i_rd_addr2];
    end

    // x0 is never marked valid, so it always reads zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_a0    <= '0;
            r_a7    <= '0;
        end else if (i_wr.en && i_wr.addr != rv32x_pkg::REG_ZERO) begin
            r_valid[i_wr.addr] <= 1'b1;
            if (i_wr.addr == rv32x_pkg::REG_A0) begin
                r_a0 <= i_wr.data;
            end
            if (i_wr.addr == rv32x_pkg::REG_A7) begin
                r_a7 <= i_wr.data;
            end
        end
    end

    assign o_rd_data1 = r_v1 ? r_q1 : '0;
    assign o_rd_data2 = r_v2 ? r_q2 : '0;
    assign o_a0       = r_a0;
    assign o_a7       = r_a7;

endmodule

// File: rtl/core/rv32x_exec.sv
`timescale 1ns / 1ps
// ============================================================================
// rv32x_exec
// Decode and execute of one RV32I word: ALU, branch compare, address adds,
// next pc and the illegal / ecall flags.
// ============================================================================
module rv32x_exec (
    input  rv32x_pkg::t_word      i_ins,
    input  rv32x_pkg::t_word      i_pc,
    input  rv32x_pkg::t_word      i_rs1,
    input  rv32x_pkg::t_word      i_rs2,
    input  rv32x_pkg::t_word      i_a0,
    input  rv32x_pkg::t_word      i_a7,
    output rv32x_pkg::t_exec_res  o_res
);

    function automatic rv32x_pkg::t_word alu(input logic [2:0] f3, input logic alt,
                                             input rv32x_pkg::t_word x,
                                             input rv32x_pkg::t_word y);
        rv32x_pkg::t_word r;
        unique case (f3)
            rv32x_pkg::F3_ADD:  r = alt ? x - y : x + y;
            rv32x_pkg::F3_SLL:  r = x << y[4:0];
            rv32x_pkg::F3_SLT:  r = {31'd0, $signed(x) < $signed(y)};
            rv32x_pkg::F3_SLTU: r = {31'd0, x < y};
            rv32x_pkg::F3_XOR:  r = x ^ y;
            rv32x_pkg::F3_SR:   r = alt ? rv32x_pkg::t_word'($signed(x) >>> y[4:0])
                                        : x >> y[4:0];
            rv32x_pkg::F3_OR:   r = x | y;
            rv32x_pkg::F3_AND:  r = x & y;
        endcase
        return r;
    endfunction

    logic [6:0]          opcode, f7;
    logic [2:0]          f3;
    rv32x_pkg::t_reg_idx rd;
    rv32x_pkg::t_word    imm_i, imm_s, imm_b, imm_j;
    rv32x_pkg::t_word    pc_plus4, ld_sum, st_sum;
    logic                wr, take;
    rv32x_pkg::t_word    val;

    assign opcode = i_ins[6:0];
    assign rd     = i_ins[11:7];
    assign f3     = i_ins[14:12];
    assign f7     = i_ins[31:25];

    assign imm_i = {{20{i_ins[31]}}, i_ins[31:20]};
    assign imm_s = {{20{i_ins[31]}}, i_ins[31:25], i_ins[11:7]};
    assign imm_b = {{19{i_ins[31]}}, i_ins[31], i_ins[7], i_ins[30:25], i_ins[11:8], 1'b0};
    assign imm_j = {{11{i_ins[31]}}, i_ins[31], i_ins[19:12], i_ins[20], i_ins[30:21],
                    1'b0};

    assign pc_plus4 = i_pc + 32'd4;
    assign ld_sum   = i_rs1 + imm_i;
    assign st_sum   = i_rs1 + imm_s;

    always_comb begin
        wr               = 1'b0;
        take             = 1'b0;
        val              = '0;
        o_res            = '0;
        o_res.next_pc    = pc_plus4;
        o_res.ld_f3      = f3;
        o_res.st_f3      = f3;
        o_res.st_data    = i_rs2;
        o_res.mem_addr   = ld_sum[rv32x_pkg::DMEM_AW-1:0];

        unique case (opcode)
            rv32x_pkg::OP_REG: begin
                if (f7 == rv32x_pkg::F7_ALT &&
                    (f3 == rv32x_pkg::F3_ADD || f3 == rv32x_pkg::F3_SR)) begin
                    val = alu(f3, 1'b1, i_rs1, i_rs2);
                    wr  = 1'b1;
                end else if (f7 == rv32x_pkg::F7_BASE) begin
                    val = alu(f3, 1'b0, i_rs1, i_rs2);
                    wr  = 1'b1;
                end else begin
                    o_res.illegal = 1'b1;
                end
            end
            rv32x_pkg::OP_IMM: begin
                if (f3 == rv32x_pkg::F3_SLL) begin
                    if (f7 == rv32x_pkg::F7_BASE) begin
                        val = alu(f3, 1'b0, i_rs1, imm_i);
                        wr  = 1'b1;
                    end else begin
                        o_res.illegal = 1'b1;
                    end
                end else if (f3 == rv32x_pkg::F3_SR) begin
                    if (f7 == rv32x_pkg::F7_BASE || f7 == rv32x_pkg::F7_ALT) begin
                        val = alu(f3, f7 == rv32x_pkg::F7_ALT, i_rs1, imm_i);
                        wr  = 1'b1;
                    end else begin
                        o_res.illegal = 1'b1;
                    end
                end else begin
                    val = alu(f3, 1'b0, i_rs1, imm_i);
                    wr  = 1'b1;
                end
            end
            rv32x_pkg::OP_LOAD: begin
                if (f3 == rv32x_pkg::F3_LB || f3 == rv32x_pkg::F3_LH ||
                    f3 == rv32x_pkg::F3_LW || f3 == rv32x_pkg::F3_LBU ||
                    f3 == rv32x_pkg::F3_LHU) begin
                    o_res.is_load = 1'b1;
                    wr            = 1'b1;
                end else begin
                    o_res.illegal = 1'b1;
                end
            end
            rv32x_pkg::OP_STORE: begin
                o_res.mem_addr = st_sum[rv32x_pkg::DMEM_AW-1:0];
                if (f3 == rv32x_pkg::F3_SB || f3 == rv32x_pkg::F3_SH ||
                    f3 == rv32x_pkg::F3_SW) begin
                    o_res.is_store = 1'b1;
                end else begin
                    o_res.illegal = 1'b1;
                end
            end
            rv32x_pkg::OP_BRANCH: begin
                unique case (f3)
                    rv32x_pkg::F3_BEQ:  take = (i_rs1 == i_rs2);
                    rv32x_pkg::F3_BNE:  take = (i_rs1 != i_rs2);
                    rv32x_pkg::F3_BLT:  take = ($signed(i_rs1) < $signed(i_rs2));
                    rv32x_pkg::F3_BGE:  take = !($signed(i_rs1) < $signed(i_rs2));
                    rv32x_pkg::F3_BLTU: take = (i_rs1 < i_rs2);
                    rv32x_pkg::F3_BGEU: take = (i_rs1 >= i_rs2);
                    default:            o_res.illegal = 1'b1;
                endcase
                if (take) begin
                    o_res.next_pc = i_pc + imm_b;
                end
            end
            rv32x_pkg::OP_LUI: begin
                val = {i_ins[31:12], 12'd0};
                wr  = 1'b1;
            end
            rv32x_pkg::OP_JAL: begin
                val           = pc_plus4;
                wr            = 1'b1;
                o_res.next_pc = i_pc + imm_j;
            end
            rv32x_pkg::OP_SYSTEM: begin
                if (i_ins == rv32x_pkg::ECALL_WORD) begin
                    o_res.ecall     = 1'b1;
                    o_res.ecall_num = i_a7;
                    o_res.ecall_arg = i_a0;
                end else begin
                    o_res.illegal = 1'b1;
                end
            end
            default: o_res.illegal = 1'b1;
        endcase

        // writes to x0 vanish entirely
        if (wr && rd != rv32x_pkg::REG_ZERO) begin
            o_res.wr  = 1'b1;
            o_res.rd  = rd;
            o_res.val = val;
        end else begin
            o_res.is_load = 1'b0;
        end
    end

endmodule

// File: rtl/core/rv32x_dmem.sv
`timescale 1ns / 1ps
// ============================================================================
// rv32x_dmem
// Byte-addressed data memory as four byte-lane banks; any 1/2/4-byte access,
// aligned or not, touches each bank at most once. Reads are registered.
// ============================================================================
module rv32x_dmem (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic                  i_wr_en,
    input  rv32x_pkg::t_dmem_addr i_addr,
    input  logic [2:0]            i_wr_f3,
    input  rv32x_pkg::t_word      i_wdata,
    output rv32x_pkg::t_word      o_rdata
);

    rv32x_pkg::t_dmem_row row_base;
    logic [1:0]           lane;
    logic [3:0]           wmask;
    logic [1:0]           r_lane;
    logic [7:0]           r_q [4];

    assign row_base = i_addr[rv32x_pkg::DMEM_AW-1:2];
    assign lane     = i_addr[1:0];

    // byte-count mask, indexed by byte offset within the access
    always_comb begin
        unique case (i_wr_f3)
            rv32x_pkg::F3_SB: wmask = 4'b0001;
            rv32x_pkg::F3_SH: wmask = 4'b0011;
            rv32x_pkg::F3_SW: wmask = 4'b1111;
            default:          wmask = 4'b0000;
        endcase
    end

    for (genvar j = 0; j < 4; j++) begin : g_bank
        logic [7:0]           bank_mem [rv32x_pkg::DMEM_ROWS];
        logic [1:0]           sel;
        rv32x_pkg::t_dmem_row row;

        // bank j holds byte offset sel; lanes below the start wrap to the next row
        assign sel = 2'(j) - lane;
        assign row = (2'(j) < lane) ? row_base + rv32x_pkg::t_dmem_row'(1) : row_base;

        always_ff @(posedge i_clk) begin
            if (i_wr_en && wmask[sel]) begin
                bank_mem[row] <= i_wdata[{sel, 3'b000} +: 8];
            end
            if (i_rd_en) begin
                r_q[j] <= bank_mem[row];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_lane <= lane;
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_rdata[8*i +: 8] = r_q[2'(i) + r_lane];
        end
    end

endmodule

// File: rtl/core/rv32i_execute_step.sv
`timescale 1ns / 1ps
// ============================================================================
// rv32i_execute_step
// RV32I integer core that executes one instruction word per transaction.
// ============================================================================
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------------------
//  i_ins    | in  | valid / ready | instruction[31:0]
//  o_res    | out | valid / ready | next_pc, reg_written, dest_reg, dest_value,
//           |     |               | mem_written, illegal, ecall_seen,
//           |     |               | ecall_number, ecall_argument
//
//  Throughput: one transaction per clock, sustained while o_res.ready holds.
//  The execute register loads on acceptance, then the memory register, then
//  the output register that drives o_res.valid.
//  The rate is set by the execute stage, which gets operands forwarded from the
//  memory stage (load data included) and the last commit.
//  Reset clears pc, register file valid bits, a0/a7 copies and the pipe; data
//  memory is not cleared, so the block is ready right after reset.
//  Stalls on o_res.ready back up stage by stage; the input keeps accepting as
//  long as a downstream slot frees in the same cycle.
//
//  Pipeline:
//    I : instruction register + registered register-file reads -> rv32x_exec
//        pc and data-memory writes commit when I advances
//    M : exec result + registered data-memory read -> load align/extend
//        register-file write commits when M advances
//    O : output register
// ============================================================================
module rv32i_execute_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rv32x_ins_if.sink    i_ins,
    rv32x_res_if.source  o_res
);

    typedef struct packed {
        rv32x_pkg::t_word    next_pc;
        logic                reg_written;
        rv32x_pkg::t_reg_idx dest_reg;
        rv32x_pkg::t_word    dest_value;
        logic                mem_written;
        logic                illegal;
        logic                ecall_seen;
        rv32x_pkg::t_word    ecall_number;
        rv32x_pkg::t_word    ecall_argument;
    } t_out;

    // ---- pipeline control --------------------------------------------------
    logic r_i_v, r_m_v, r_o_v;
    logic o_free, m_adv, m_free, i_adv, i_free, in_acc;

    assign o_free = !r_o_v || o_res.ready;
    assign m_adv  = r_m_v && o_free;
    assign m_free = !r_m_v || m_adv;
    assign i_adv  = r_i_v && m_free;
    assign i_free = !r_i_v || i_adv;
    assign in_acc = i_ins.valid && i_free;

    assign i_ins.ready = i_free;

    // ---- stage I -----------------------------------------------------------
    rv32x_pkg::t_word     r_ins;
    rv32x_pkg::t_word     r_pc;
    rv32x_pkg::t_reg_idx  rs1_addr, rs2_addr;
    rv32x_pkg::t_word     rf_rs1, rf_rs2, rf_a0, rf_a7;
    rv32x_pkg::t_word     op_a, op_b, op_a0, op_a7;
    rv32x_pkg::t_exec_res ex;
    rv32x_pkg::t_rf_wr    rf_wr;

    // commit seen by the register file on the last edge; its read missed it
    logic                 r_wb_en;
    rv32x_pkg::t_reg_idx  r_wb_rd;
    rv32x_pkg::t_word     r_wb_val;

    // stage M
    rv32x_pkg::t_exec_res r_m;
    rv32x_pkg::t_word     mem_rdata, ld_val, m_val;

    // stage O
    t_out                 r_o;

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ins <= i_ins.instruction;
        end
    end

    // reread every cycle so a held instruction keeps picking up commits
    assign rs1_addr = in_acc ? i_ins.instruction[19:15] : r_ins[19:15];
    assign rs2_addr = in_acc ? i_ins.instruction[24:20] : r_ins[24:20];

    rv32x_regfile u_regfile (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_addr1 (rs1_addr),
        .i_rd_addr2 (rs2_addr),
        .o_rd_data1 (rf_rs1),
        .o_rd_data2 (rf_rs2),
        .i_wr       (rf_wr),
        .o_a0       (rf_a0),
        .o_a7       (rf_a7)
    );

    // forwarding: memory stage first, then last commit, then the file
    always_comb begin
        if (r_m_v && r_m.wr && r_m.rd == r_ins[19:15]) begin
            op_a = m_val;
        end else if (r_wb_en && r_wb_rd == r_ins[19:15]) begin
            op_a = r_wb_val;
        end else begin
            op_a = rf_rs1;
        end

        if (r_m_v && r_m.wr && r_m.rd == r_ins[24:20]) begin
            op_b = m_val;
        end else if (r_wb_en && r_wb_rd == r_ins[24:20]) begin
            op_b = r_wb_val;
        end else begin
            op_b = rf_rs2;
        end

        // a0/a7 copies already include every commit
        op_a0 = (r_m_v && r_m.wr && r_m.rd == rv32x_pkg::REG_A0) ? m_val : rf_a0;
        op_a7 = (r_m_v && r_m.wr && r_m.rd == rv32x_pkg::REG_A7) ? m_val : rf_a7;
    end

    rv32x_exec u_exec (
        .i_ins (r_ins),
        .i_pc  (r_pc),
        .i_rs1 (op_a),
        .i_rs2 (op_b),
        .i_a0  (op_a0),
        .i_a7  (op_a7),
        .o_res (ex)
    );

    rv32x_dmem u_dmem (
        .i_clk   (i_clk),
        .i_rd_en (i_adv),
        .i_wr_en (i_adv && ex.is_store),
        .i_addr  (ex.mem_addr),
        .i_wr_f3 (ex.st_f3),
        .i_wdata (ex.st_data),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m <= ex;
        end
    end

    // ---- stage M: load align / extend --------------------------------------
    always_comb begin
        unique case (r_m.ld_f3)
            rv32x_pkg::F3_LB:  ld_val = {{24{mem_rdata[7]}}, mem_rdata[7:0]};
            rv32x_pkg::F3_LH:  ld_val = {{16{mem_rdata[15]}}, mem_rdata[15:0]};
            rv32x_pkg::F3_LW:  ld_val = mem_rdata;
            rv32x_pkg::F3_LBU: ld_val = {24'd0, mem_rdata[7:0]};
            rv32x_pkg::F3_LHU: ld_val = {16'd0, mem_rdata[15:0]};
            default:           ld_val = '0;
        endcase
    end

    assign m_val = r_m.is_load ? ld_val : r_m.val;

    assign rf_wr.en   = m_adv && r_m.wr;
    assign rf_wr.addr = r_m.rd;
    assign rf_wr.data = m_val;

    always_ff @(posedge i_clk) begin
        r_wb_rd  <= r_m.rd;
        r_wb_val <= m_val;
    end

    always_ff @(posedge i_clk) begin
        if (m_adv) begin
            r_o.next_pc        <= r_m.next_pc;
            r_o.reg_written    <= r_m.wr;
            r_o.dest_reg       <= r_m.rd;
            r_o.dest_value     <= m_val;
            r_o.mem_written    <= r_m.is_store;
            r_o.illegal        <= r_m.illegal;
            r_o.ecall_seen     <= r_m.ecall;
            r_o.ecall_number   <= r_m.ecall_num;
            r_o.ecall_argument <= r_m.ecall_arg;
        end
    end

    // ---- control registers -------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_v   <= 1'b0;
            r_m_v   <= 1'b0;
            r_o_v   <= 1'b0;
            r_pc    <= '0;
            r_wb_en <= 1'b0;
        end else begin
            r_i_v   <= in_acc || (r_i_v && !i_adv);
            r_m_v   <= i_adv || (r_m_v && !m_adv);
            r_o_v   <= m_adv || (r_o_v && !o_res.ready);
            r_wb_en <= rf_wr.en;
            if (i_adv) begin
                r_pc <= ex.next_pc;
            end
        end
    end

    // ---- outputs -----------------------------------------------------------
    assign o_res.valid          = r_o_v;
    assign o_res.next_pc        = r_o.next_pc;
    assign o_res.reg_written    = r_o.reg_written;
    assign o_res.dest_reg       = r_o.dest_reg;
    assign o_res.dest_value     = r_o.dest_value;
    assign o_res.mem_written    = r_o.mem_written;
    assign o_res.illegal        = r_o.illegal;
    assign o_res.ecall_seen     = r_o.ecall_seen;
    assign o_res.ecall_number   = r_o.ecall_number;
    assign o_res.ecall_argument = r_o.ecall_argument;

`ifndef NO_ASSERTIONS
    // a commit never targets x0
    a_commit_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_wr.en |-> rf_wr.addr != rv32x_pkg::REG_ZERO)
        else $error("register commit to x0");

    // x0 operand reads zero after forwarding
    a_x0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i_v && r_ins[19:15] == rv32x_pkg::REG_ZERO) |-> op_a == '0)
        else $error("x0 operand not zero");

    // an illegal result has no side effects
    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_v && r_o.illegal) |-> (!r_o.reg_written && !r_o.mem_written &&
                                    !r_o.ecall_seen))
        else $error("illegal result with side effect");

    // an empty execute stage always takes input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_i_v |-> i_ins.ready)
        else $error("input stalled with empty execute stage");

    // pc follows the retired instruction
    a_pc_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_adv |=> r_o.next_pc == r_pc || r_m_v || r_i_v)
        else $error("pc out of step with retired instruction");
`endif

endmodule

// File: tb/rv32i_retire_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// rv32i_retire_checker
// Watches both channels of rv32i_execute_step, keeps its own architectural
// state (pc, register file, data memory), predicts the retire record of
// every accepted instruction and compares it, field by field, in order.
// ============================================================================
module rv32i_retire_checker
    import rv32x_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    rv32x_ins_if   i_ins,
    rv32x_res_if   i_res,
    output int     o_fail_count,
    output int     o_pending
);

    typedef struct packed {
        t_word    next_pc;
        logic     reg_written;
        t_reg_idx dest_reg;
        t_word    dest_value;
        logic     mem_written;
        logic     illegal;
        logic     ecall_seen;
        t_word    ecall_number;
        t_word    ecall_argument;
    } t_retire;

    t_word      arch_pc;
    t_word      arch_rf  [REG_COUNT];
    logic [7:0] arch_mem [DATA_MEM_BYTES];
    t_retire    retire_q [$];

    function automatic t_word mem_read(input t_word addr, input int nbytes);
        t_word v;
        t_word a;
        v = '0;
        for (int i = 0; i < nbytes; i++) begin
            a = addr + t_word'(i);
            v |= t_word'(arch_mem[a[DMEM_AW-1:0]]) << (8 * i);
        end
        return v;
    endfunction

    function automatic void mem_write(input t_word addr, input t_word data, input int nbytes);
        t_word a;
        for (int i = 0; i < nbytes; i++) begin
            a = addr + t_word'(i);
            arch_mem[a[DMEM_AW-1:0]] = data[8*i +: 8];
        end
    endfunction

    function automatic t_word alu_op(input logic [2:0] f3, input logic alt,
                                     input t_word a, input t_word b);
        case (f3)
            F3_ADD:  return alt ? a - b : a + b;
            F3_SLL:  return a << b[4:0];
            F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
            F3_XOR:  return a ^ b;
            F3_SR:   return alt ? t_word'($signed(a) >>> b[4:0]) : a >> b[4:0];
            F3_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    // architectural effect of one instruction word, returns its retire record
    function automatic t_retire execute_word(input t_word ins);
        t_retire    r;
        logic [6:0] opcode;
        logic [6:0] f7;
        logic [2:0] f3;
        t_reg_idx   rd;
        t_word      a, b, imm_i, imm_s, imm_b, imm_j;
        t_word      addr, raw, val, nxt;
        logic       wr;
        logic       take;
        opcode = ins[6:0];
        rd     = ins[11:7];
        f3     = ins[14:12];
        f7     = ins[31:25];
        a      = arch_rf[ins[19:15]];
        b      = arch_rf[ins[24:20]];
        imm_i  = {{20{ins[31]}}, ins[31:20]};
        imm_s  = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        imm_b  = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        imm_j  = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        r      = '0;
        nxt    = arch_pc + 32'd4;
        val    = '0;
        wr     = 1'b0;
        take   = 1'b0;
        case (opcode)
            OP_REG: begin
                if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)) begin
                    val = alu_op(f3, 1'b1, a, b);
                    wr  = 1'b1;
                end else if (f7 == F7_BASE) begin
                    val = alu_op(f3, 1'b0, a, b);
                    wr  = 1'b1;
                end else begin
                    r.illegal = 1'b1;
                end
            end
            OP_IMM: begin
                if (f3 == F3_SLL) begin
                    if (f7 == F7_BASE) begin
                        val = alu_op(F3_SLL, 1'b0, a, imm_i);
                        wr  = 1'b1;
                    end else begin
                        r.illegal = 1'b1;
                    end
                end else if (f3 == F3_SR) begin
                    if (f7 == F7_BASE || f7 == F7_ALT) begin
                        val = alu_op(F3_SR, f7 == F7_ALT, a, imm_i);
                        wr  = 1'b1;
                    end else begin
                        r.illegal = 1'b1;
                    end
                end else begin
                    val = alu_op(f3, 1'b0, a, imm_i);
                    wr  = 1'b1;
                end
            end
            OP_LOAD: begin
                addr = a + imm_i;
                wr   = 1'b1;
                case (f3)
                    F3_LB: begin
                        raw = mem_read(addr, 1);
                        val = {{24{raw[7]}}, raw[7:0]};
                    end
                    F3_LH: begin
                        raw = mem_read(addr, 2);
                        val = {{16{raw[15]}}, raw[15:0]};
                    end
                    F3_LW:   val = mem_read(addr, 4);
                    F3_LBU:  val = mem_read(addr, 1);
                    F3_LHU:  val = mem_read(addr, 2);
                    default: begin
                        wr        = 1'b0;
                        r.illegal = 1'b1;
                    end
                endcase
            end
            OP_STORE: begin
                addr = a + imm_s;
                if (f3 inside {F3_SB, F3_SH, F3_SW}) begin
                    mem_write(addr, b, 1 << f3);
                    r.mem_written = 1'b1;
                end else begin
                    r.illegal = 1'b1;
                end
            end
            OP_BRANCH: begin
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = ($signed(a) < $signed(b));
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: r.illegal = 1'b1;
                endcase
                if (take) nxt = arch_pc + imm_b;
            end
            OP_LUI: begin
                val = {ins[31:12], 12'h000};
                wr  = 1'b1;
            end
            OP_JAL: begin
                val = arch_pc + 32'd4;
                wr  = 1'b1;
                nxt = arch_pc + imm_j;
            end
            OP_SYSTEM: begin
                if (ins == ECALL_WORD) begin
                    r.ecall_seen     = 1'b1;
                    r.ecall_number   = arch_rf[REG_A7];
                    r.ecall_argument = arch_rf[REG_A0];
                end else begin
                    r.illegal = 1'b1;
                end
            end
            default: r.illegal = 1'b1;
        endcase
        // x0 writes vanish, record shows nothing written
        if (wr && rd != REG_ZERO) begin
            arch_rf[rd]   = val;
            r.reg_written = 1'b1;
            r.dest_reg    = rd;
            r.dest_value  = val;
        end
        arch_pc   = nxt;
        r.next_pc = nxt;
        return r;
    endfunction

    task automatic check_field(input string name, input t_word want, input t_word got);
        if (got !== want) begin
            $error("retire field %s: expected %h, actual %h", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_retire want;
        if (!i_rst_n) begin
            arch_pc = '0;
            for (int r = 0; r < REG_COUNT; r++) arch_rf[r] = '0;
            retire_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                if (retire_q.size() == 0) begin
                    $error("retire transaction with no instruction outstanding");
                    o_fail_count++;
                end else begin
                    want = retire_q.pop_front();
                    check_field("next_pc",        want.next_pc,        i_res.next_pc);
                    check_field("reg_written",    want.reg_written,    i_res.reg_written);
                    check_field("dest_reg",       want.dest_reg,       i_res.dest_reg);
                    check_field("dest_value",     want.dest_value,     i_res.dest_value);
                    check_field("mem_written",    want.mem_written,    i_res.mem_written);
                    check_field("illegal",        want.illegal,        i_res.illegal);
                    check_field("ecall_seen",     want.ecall_seen,     i_res.ecall_seen);
                    check_field("ecall_number",   want.ecall_number,   i_res.ecall_number);
                    check_field("ecall_argument", want.ecall_argument, i_res.ecall_argument);
                end
            end
            if (i_ins.valid && i_ins.ready)
                retire_q.push_back(execute_word(i_ins.instruction));
        end
        o_pending = retire_q.size();
    end

endmodule

// File: tb/tb_rv32i_execute_step.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_rv32i_execute_step
// Drives instruction words into rv32i_execute_step: a directed opening on the
// ISA corner cases, then random programs under four back-pressure phases.
// A checker beside the block predicts and compares every retire record.
// ============================================================================
module tb_rv32i_execute_step;
    import rv32x_pkg::*;

    // encodings outside the supported set, used to provoke the illegal flag
    localparam logic [6:0] OP_AUIPC   = 7'h17;
    localparam logic [6:0] OP_JALR    = 7'h67;
    localparam logic [6:0] OP_FENCE   = 7'h0F;
    localparam logic [6:0] OP_LOAD_FP = 7'h07;
    localparam logic [6:0] F7_BAD     = 7'h01;
    localparam logic [2:0] F3_LD_BAD  = 3'd3;
    localparam logic [2:0] F3_ST_BAD  = 3'd3;
    localparam logic [2:0] F3_BR_BAD  = 3'd2;
    localparam t_word      EBREAK_WORD    = 32'h0010_0073;
    localparam t_word      COMPRESSED_NOP = 32'h0000_0001;

    localparam int RANDOM_PER_PHASE = 132;
    localparam int DRAIN_CYCLES     = 12;      // quiet cycles after the last retire record, as margin
    localparam int CYCLE_LIMIT      = 400000;

    // idle / stall percentages per random phase: none, sender, receiver, both
    localparam int SRC_IDLE  [4] = '{0, 65, 0, 28};
    localparam int SNK_STALL [4] = '{0, 0, 65, 28};

    logic i_clk;
    logic i_rst_n;

    rv32x_ins_if ins_ch ();
    rv32x_res_if res_ch ();

    int mismatch_count;
    int results_pending;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int cycle_count   = 0;

    // bytes of data memory known to hold a stored value; loads only touch these
    bit          written_map [DATA_MEM_BYTES];
    logic [11:0] stored_imm_q [$];

    rv32i_execute_step dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ins   (ins_ch),
        .o_res   (res_ch)
    );

    rv32i_retire_checker retire_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ins        (ins_ch),
        .i_res        (res_ch),
        .o_fail_count (mismatch_count),
        .o_pending    (results_pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // watchdog: a hung pipe ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("watchdog expired after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // instruction encoders
    // ------------------------------------------------------------------
    function automatic t_word enc_r(input logic [6:0] f7, input t_reg_idx rs2,
                                    input t_reg_idx rs1, input logic [2:0] f3,
                                    input t_reg_idx rd, input logic [6:0] op);
        return {f7, rs2, rs1, f3, rd, op};
    endfunction

    function automatic t_word enc_i(input logic [11:0] imm, input t_reg_idx rs1,
                                    input logic [2:0] f3, input t_reg_idx rd,
                                    input logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic t_word enc_s(input logic [2:0] f3, input t_reg_idx rs2,
                                    input t_reg_idx rs1, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
    endfunction

    function automatic t_word enc_b(input logic [2:0] f3, input t_reg_idx rs2,
                                    input t_reg_idx rs1, input logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
    endfunction

    function automatic t_word enc_u(input logic [19:0] imm, input t_reg_idx rd);
        return {imm, rd, OP_LUI};
    endfunction

    function automatic t_word enc_j(input logic [20:0] imm, input t_reg_idx rd);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
    endfunction

    // ------------------------------------------------------------------
    // data memory bookkeeping for x0-based stores
    // ------------------------------------------------------------------
    function automatic t_dmem_addr byte_slot(input logic [11:0] imm, input int i);
        t_word a;
        a = {{20{imm[11]}}, imm} + t_word'(i);    // wraps mod 2^32, then mod size
        return a[DMEM_AW-1:0];
    endfunction

    function automatic void mark_store(input logic [11:0] imm, input int nbytes);
        for (int i = 0; i < nbytes; i++) written_map[byte_slot(imm, i)] = 1'b1;
        stored_imm_q.push_back(imm);
    endfunction

    // ------------------------------------------------------------------
    // random field helpers
    // ------------------------------------------------------------------
    // Mostly a small working set so results feed later operands (forwarding
    // paths), with a0/a7 in it so ecalls see live values.
    function automatic t_reg_idx pick_reg();
        int k;
        k = $urandom_range(11);
        if (k < 7)   return t_reg_idx'(k + 1);
        if (k == 7)  return REG_A0;
        if (k == 8)  return REG_A7;
        return t_reg_idx'($urandom_range(31));
    endfunction

    function automatic logic [11:0] rand_imm12();
        case ($urandom_range(15))
            0:       return 12'h7FF;
            1:       return 12'h800;
            2:       return 12'hFFF;
            3:       return 12'h000;
            default: return 12'($urandom);
        endcase
    endfunction

    // One random instruction. Most are well-formed with random content; a
    // slice is deliberately broken and a slice is raw noise. Loads only use
    // x0 as base and only hit bytes recorded in written_map.
    function automatic t_word random_instruction();
        t_word       w;
        logic [6:0]  f7;
        logic [2:0]  f3;
        logic [11:0] imm;
        t_reg_idx    rd, rs1, rs2;
        int          pick;
        int          nbytes;
        bit          ok;
        pick = $urandom_range(99);
        rd   = pick_reg();
        rs1  = pick_reg();
        rs2  = pick_reg();
        f3   = 3'($urandom);
        imm  = rand_imm12();
        if (pick < 18) begin
            f7 = ((f3 == F3_ADD || f3 == F3_SR) && $urandom_range(1)) ? F7_ALT : F7_BASE;
            w  = enc_r(f7, rs2, rs1, f3, rd, OP_REG);
        end else if (pick < 36) begin
            if (f3 == F3_SLL)
                imm = {F7_BASE, 5'($urandom)};
            else if (f3 == F3_SR)
                imm = {($urandom_range(1) ? F7_ALT : F7_BASE), 5'($urandom)};
            w = enc_i(imm, rs1, f3, rd, OP_IMM);
        end else if (pick < 50 && stored_imm_q.size() != 0) begin
            imm = stored_imm_q[$urandom_range(stored_imm_q.size() - 1)];
            case ($urandom_range(4))
                0:       f3 = F3_LB;
                1:       f3 = F3_LH;
                2:       f3 = F3_LW;
                3:       f3 = F3_LBU;
                default: f3 = F3_LHU;
            endcase
            nbytes = (f3 == F3_LW) ? 4 : (f3 == F3_LH || f3 == F3_LHU) ? 2 : 1;
            ok = 1'b1;
            for (int i = 0; i < nbytes; i++) ok &= written_map[byte_slot(imm, i)];
            // first byte is always written, so a byte load is always safe
            if (!ok) f3 = $urandom_range(1) ? F3_LB : F3_LBU;
            w = enc_i(imm, REG_ZERO, f3, rd, OP_LOAD);
        end else if (pick < 62) begin
            case ($urandom_range(2))
                0:       f3 = F3_SB;
                1:       f3 = F3_SH;
                default: f3 = F3_SW;
            endcase
            if ($urandom_range(3) != 0) begin
                // cluster half of the x0-based stores around 0 so they overlap and wrap
                if ($urandom_range(1)) imm = {{6{imm[11]}}, imm[5:0]};
                mark_store(imm, 1 << f3);
                w = enc_s(f3, rs2, REG_ZERO, imm);
            end else begin
                w = enc_s(f3, rs2, t_reg_idx'($urandom_range(31, 1)), imm);
            end
        end else if (pick < 74) begin
            case ($urandom_range(5))
                0:       f3 = F3_BEQ;
                1:       f3 = F3_BNE;
                2:       f3 = F3_BLT;
                3:       f3 = F3_BGE;
                4:       f3 = F3_BLTU;
                default: f3 = F3_BGEU;
            endcase
            w = enc_b(f3, rs2, rs1, 13'($urandom));
        end else if (pick < 79) begin
            w = enc_u(20'($urandom), rd);
        end else if (pick < 83) begin
            w = enc_j(21'($urandom), rd);
        end else if (pick < 86) begin
            w = ECALL_WORD;
        end else if (pick < 94) begin
            case ($urandom_range(6))
                0: begin
                    f7 = 7'($urandom);
                    while (f7 inside {F7_BASE, F7_ALT}) f7 = 7'($urandom);
                    w = enc_r(f7, rs2, rs1, f3, rd, OP_REG);
                end
                1: begin
                    f7 = 7'($urandom);
                    if ($urandom_range(1)) begin
                        while (f7 == F7_BASE) f7 = 7'($urandom);
                        f3 = F3_SLL;
                    end else begin
                        while (f7 inside {F7_BASE, F7_ALT}) f7 = 7'($urandom);
                        f3 = F3_SR;
                    end
                    w = enc_i({f7, rs2}, rs1, f3, rd, OP_IMM);
                end
                2: begin
                    while (f3 inside {F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU}) f3 = 3'($urandom);
                    w = enc_i(imm, REG_ZERO, f3, rd, OP_LOAD);
                end
                3: begin
                    while (f3 inside {F3_SB, F3_SH, F3_SW}) f3 = 3'($urandom);
                    w = enc_s(f3, rs2, rs1, imm);
                end
                4: begin
                    while (f3 inside {F3_BEQ, F3_BNE, F3_BLT, F3_BGE, F3_BLTU, F3_BGEU})
                        f3 = 3'($urandom);
                    w = enc_b(f3, rs2, rs1, 13'($urandom));
                end
                5: begin
                    w = $urandom;
                    w[6:0] = OP_SYSTEM;
                    if (w == ECALL_WORD) w[20] = 1'b1;
                end
                default: begin
                    w = $urandom;
                    case ($urandom_range(3))
                        0:       w[6:0] = OP_AUIPC;
                        1:       w[6:0] = OP_JALR;
                        2:       w[6:0] = OP_FENCE;
                        default: if (&w[1:0]) w[0] = 1'b0;   // compressed space
                    endcase
                end
            endcase
        end else begin
            // raw noise; a noise load could read unwritten memory, divert it
            w = $urandom;
            if (w[6:0] == OP_LOAD) w[6:0] = OP_LOAD_FP;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // sender: one transaction, with random idle cycles in front of it.
    // Returns once the instruction channel has accepted the word.
    // ------------------------------------------------------------------
    task automatic send_word(input t_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            ins_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        ins_ch.valid       <= 1'b1;
        ins_ch.instruction <= w;
        @(posedge i_clk);
        while (!ins_ch.ready) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        ins_ch.valid       = 1'b0;
        ins_ch.instruction = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---------------- directed opening, no idling ----------------
        send_word(enc_u(20'hFFFFF, 5'd1));                          // x1 = FFFFF000
        send_word(enc_i(12'h7FF, 5'd1, F3_ADD, 5'd1, OP_IMM));      // max positive imm
        send_word(enc_i(12'h800, REG_ZERO, F3_ADD, 5'd2, OP_IMM));  // min negative imm
        send_word(enc_i(12'h005, 5'd1, F3_ADD, REG_ZERO, OP_IMM));  // write to x0 dropped
        send_word(enc_i({F7_ALT, 5'd31}, 5'd1, F3_SR, 5'd3, OP_IMM));   // SRAI by 31
        send_word(enc_i({F7_BASE, 5'd31}, 5'd1, F3_SR, 5'd4, OP_IMM));  // SRLI by 31
        send_word(enc_r(F7_ALT, 5'd1, REG_ZERO, F3_ADD, 5'd6, OP_REG)); // SUB
        // word store at -1: bytes at the top of memory and wrapped to 0..2
        mark_store(12'hFFF, 4);
        send_word(enc_s(F3_SW, 5'd1, REG_ZERO, 12'hFFF));
        send_word(enc_i(12'hFFF, REG_ZERO, F3_LW, 5'd8, OP_LOAD));
        send_word(enc_i(12'h001, REG_ZERO, F3_LH, 5'd9, OP_LOAD));  // misaligned half
        mark_store(12'h7FF, 1);
        send_word(enc_s(F3_SB, 5'd1, REG_ZERO, 12'h7FF));
        send_word(enc_i(12'h7FF, REG_ZERO, F3_LB, REG_A0, OP_LOAD)); // sign-extended byte
        send_word(enc_i(12'h7FF, REG_ZERO, F3_ADD, REG_A7, OP_IMM));
        send_word(ECALL_WORD);
        send_word(enc_b(F3_BEQ, REG_ZERO, REG_ZERO, 13'h0002));     // misaligned target
        send_word(enc_b(F3_BLTU, 5'd1, REG_ZERO, 13'h1000));        // min offset, pc wraps
        send_word(enc_j(21'h100000, 5'd1));                         // JAL min offset
        // illegal encodings of every kind
        send_word(enc_r(F7_BAD, 5'd2, 5'd1, F3_ADD, 5'd5, OP_REG));
        send_word(enc_i({F7_ALT, 5'd3}, 5'd1, F3_SLL, 5'd5, OP_IMM));
        send_word(enc_i(12'h000, REG_ZERO, F3_LD_BAD, 5'd5, OP_LOAD));
        send_word(enc_s(F3_ST_BAD, 5'd2, REG_ZERO, 12'h010));
        send_word(enc_b(F3_BR_BAD, 5'd2, 5'd1, 13'h0010));
        send_word(EBREAK_WORD);
        send_word({20'h12345, 5'd5, OP_AUIPC});
        send_word(COMPRESSED_NOP);

        // ---------------- random programs, four pressure phases ----------------
        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct  = SRC_IDLE[ph];
            snk_stall_pct = SNK_STALL[ph];
            repeat (RANDOM_PER_PHASE) send_word(random_instruction());
        end
        ins_ch.valid <= 1'b0;
        // let the checker count the last transaction before polling
        @(posedge i_clk);

        // drain: every outstanding retire record, then a few quiet cycles
        while (results_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && results_pending == 0) begin
            $display("end of test: clean");
        end else begin
            if (results_pending != 0)
                $error("%0d retire records never arrived", results_pending);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
